// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk and switched off while rst is high.
`define TPK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle, consequent in the next.
`define TPK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tpk_pkg.sv
// Package with the types and codes shared by the byte packer modules.
package tpk_pkg;

  localparam int TPK_CMD_W      = 3;
  localparam int TPK_STATUS_W   = 2;
  localparam int TPK_VALUE_W    = 64;
  localparam int TPK_COUNT_W    = 4;
  localparam int TPK_QUEUE_DEPTH = 2;

  localparam logic [TPK_CMD_W-1:0] CMD_BYTE   = 3'd0;
  localparam logic [TPK_CMD_W-1:0] CMD_INT29  = 3'd1;
  localparam logic [TPK_CMD_W-1:0] CMD_UINT29 = 3'd2;
  localparam logic [TPK_CMD_W-1:0] CMD_INT32  = 3'd3;
  localparam logic [TPK_CMD_W-1:0] CMD_UINT32 = 3'd4;
  localparam logic [TPK_CMD_W-1:0] CMD_DOUBLE = 3'd5;

  localparam logic [TPK_STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [TPK_STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [TPK_STATUS_W-1:0] ST_BADCMD = 2'd2;

  // One classified request: its bytes left-aligned (first byte in the top
  // byte lane), how many of them to send, and the status of the request.
  typedef struct packed {
    logic [TPK_VALUE_W-1:0]  bytes;
    logic [TPK_COUNT_W-1:0]  count;
    logic [TPK_STATUS_W-1:0] status;
  } tpk_item_t;

endpackage

// File: rtl/tpk_front.sv
// Front end: range checks a request and builds its byte sequence.
module tpk_front
  import tpk_pkg::*;
(
  input  logic [TPK_CMD_W-1:0]          command,
  input  logic signed [TPK_VALUE_W-1:0] value,
  output tpk_item_t                     item
);

  // Variable-length U29 form: seven bits per byte, continuation bit set on
  // all but the last, except that the four-byte form ends in a full eight bits.
  function automatic tpk_item_t u29_pack(input logic [28:0] v);
    tpk_item_t r;
    r.status = ST_OK;
    r.bytes  = '0;
    if (v[28:7] == '0) begin
      r.bytes[63:56] = {1'b0, v[6:0]};
      r.count        = 4'd1;
    end else if (v[28:14] == '0) begin
      r.bytes[63:48] = {1'b1, v[13:7], 1'b0, v[6:0]};
      r.count        = 4'd2;
    end else if (v[28:21] == '0) begin
      r.bytes[63:40] = {1'b1, v[20:14], 1'b1, v[13:7], 1'b0, v[6:0]};
      r.count        = 4'd3;
    end else begin
      r.bytes[63:32] = {1'b1, v[28:22], 1'b1, v[21:15], 1'b1, v[14:8], v[7:0]};
      r.count        = 4'd4;
    end
    return r;
  endfunction

  logic [TPK_VALUE_W-1:0] raw;
  tpk_item_t              err_item;

  assign raw = value;

  always_comb begin
    err_item.bytes  = '0;
    err_item.count  = 4'd1;
    err_item.status = ST_RANGE;
    item            = err_item;
    unique case (command)
      CMD_BYTE: begin
        if (raw[63:8] == '0) begin
          item.bytes  = {raw[7:0], 56'd0};
          item.status = ST_OK;
        end
      end
      CMD_INT29: begin
        if ((&raw[63:28]) || (raw[63:28] == '0)) begin
          item = u29_pack(raw[28:0]);
        end
      end
      CMD_UINT29: begin
        if (raw[63:29] == '0) begin
          item = u29_pack(raw[28:0]);
        end
      end
      CMD_INT32: begin
        if ((&raw[63:31]) || (raw[63:31] == '0)) begin
          item.bytes  = {raw[31:0], 32'd0};
          item.count  = 4'd4;
          item.status = ST_OK;
        end
      end
      CMD_UINT32: begin
        if (raw[63:32] == '0) begin
          item.bytes  = {raw[31:0], 32'd0};
          item.count  = 4'd4;
          item.status = ST_OK;
        end
      end
      CMD_DOUBLE: begin
        item.bytes  = raw;
        item.count  = 4'd8;
        item.status = ST_OK;
      end
      default: begin
        item.status = ST_BADCMD;
      end
    endcase
  end

endmodule

// File: rtl/tpk_queue.sv
// Small queue of classified requests between the front and back ends.
module tpk_queue
  import tpk_pkg::*;
#(
  parameter int DEPTH = TPK_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  tpk_item_t push_item,
  input  logic      pop,
  output tpk_item_t head,
  output logic      empty,
  output logic      full
);

  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W = $clog2(DEPTH + 1);

  tpk_item_t         mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign empty   = (fill == '0);
  assign full    = (fill == FILL_W'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// File: rtl/tpk_back.sv
// Back end: sends the bytes of each queued request, one a cycle.
module tpk_back
  import tpk_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  tpk_item_t               head,
  input  logic                    empty,
  output logic                    pop,
  output logic                    strobe,
  output logic [7:0]              out_byte,
  output logic                    last,
  output logic [TPK_STATUS_W-1:0] status
);

  logic                    active;
  logic [TPK_VALUE_W-1:0]  cur_bytes;
  logic [TPK_COUNT_W-1:0]  remaining;
  logic [TPK_STATUS_W-1:0] cur_status;
  logic                    on_last;
  logic                    load;

  assign on_last = (remaining == 4'd1);
  // Take the next request when idle or while sending the final byte.
  assign load    = !active || on_last;
  assign pop     = load && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      remaining <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= active;
      if (load) begin
        active <= !empty;
        if (!empty) begin
          remaining <= head.count;
        end
      end else begin
        remaining <= remaining - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_byte <= cur_bytes[63:56];
    last     <= on_last;
    status   <= cur_status;
    if (load) begin
      cur_bytes  <= head.bytes;
      cur_status <= head.status;
    end else begin
      cur_bytes <= {cur_bytes[55:0], 8'd0};
    end
  end

endmodule

// File: rtl/typed_value_byte_packer_unit.sv
// Top level of the typed value byte packer.
//
// Each request carries a command and a 64-bit value and is turned into its
// serialised bytes, sent one per cycle on out_byte with strobe high and
// last marking the final byte of the request. A raw byte gives one byte, a
// 29-bit integer one to four bytes in the variable-length U29 form, a
// 32-bit integer four bytes and a double eight bytes, big-endian. A value
// out of range for its command, or an unknown command, gives a single
// result with out_byte zero, last high and a non-zero status. A request is
// taken at a rising edge with start high and busy low. While a request is
// being sent the output runs at one byte per cycle; the byte sender in the
// back end sets this rate. When the block is idle a taken request is
// written into the queue, loaded into the sender's shift register and then
// registered onto out_byte, and consecutive requests follow each other on
// the output with no gap. The receiver cannot stall: every result is shown
// for exactly one cycle. Requests are classified on entry and wait in a
// queue of QUEUE_DEPTH entries; busy is high while that queue is full.
module typed_value_byte_packer_unit
  import tpk_pkg::*;
#(
  parameter int QUEUE_DEPTH = TPK_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [TPK_CMD_W-1:0]          command,
  input  logic signed [TPK_VALUE_W-1:0] value,
  output logic                          strobe,
  output logic [7:0]                    out_byte,
  output logic                          last,
  output logic [TPK_STATUS_W-1:0]       status
);

  tpk_item_t front_item;
  tpk_item_t head;
  logic      q_empty;
  logic      q_full;
  logic      pop;

  // The front end is purely combinational: a request is checked and packed
  // in the cycle it is taken and written straight into the queue.
  tpk_front u_front (
    .command (command),
    .value   (value),
    .item    (front_item)
  );

  assign busy = q_full;

  tpk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start && !busy),
    .push_item (front_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // The back end takes the next request from the queue while it sends the
  // final byte of the current one, so the output stays fully occupied while the queue holds requests.
  tpk_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (q_empty),
    .pop      (pop),
    .strobe   (strobe),
    .out_byte (out_byte),
    .last     (last),
    .status   (status)
  );

endmodule

// File: rtl/tpk_checker.sv
// Port-level checker for the byte packer, bound to the top level.
`include "assert_macros.svh"

module tpk_checker
  import tpk_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    strobe,
  input logic [7:0]              out_byte,
  input logic                    last,
  input logic [TPK_STATUS_W-1:0] status
);

  // An error result is a single zero byte that closes its request.
  `TPK_ASSERT(a_err_single, !(strobe && status != ST_OK) || (last && out_byte == 8'd0), "error result malformed")

  // Status never takes the unused code while strobe is high.
  `TPK_ASSERT(a_status_code, !strobe || status == ST_OK || status == ST_RANGE || status == ST_BADCMD, "bad status code")

  // The bytes of one request leave on consecutive cycles.
  `TPK_ASSERT_NEXT(a_run_contiguous, strobe && !last, strobe, "gap inside a byte run")

  // The queue can only fill up because a request was offered.
  `TPK_ASSERT(a_busy_cause, !$rose(busy) || $past(start), "busy rose without a request")

endmodule

bind typed_value_byte_packer_unit tpk_checker u_tpk_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .strobe   (strobe),
  .out_byte (out_byte),
  .last     (last),
  .status   (status)
);

// File: dv/tb_typed_value_byte_packer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for typed_value_byte_packer_unit, with its byte predictor.

// Works out the bytes that each accepted request must produce and checks the
// bytes that leave the block against them in order.
class packed_byte_tracker;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic [1:0] st;
  } packed_byte_t;

  packed_byte_t owed[$];
  int unsigned  n_requests;
  int unsigned  n_faults;
  int unsigned  n_bytes;
  int unsigned  n_errors;
  int unsigned  per_cmd[8];

  // Serialises one request into the bytes it owes, or into a single fault result.
  function void note_request(logic [2:0] cmd, logic [63:0] raw);
    logic        neg;
    logic [63:0] mag;
    logic [28:0] u;
    logic [1:0]  verdict;
    logic [7:0]  seq[$];
    neg = raw[63];
    mag = neg ? (~raw + 64'd1) : raw;
    u = raw[28:0];
    verdict = tpk_pkg::ST_OK;
    n_requests++;
    per_cmd[cmd]++;
    case (cmd)
      tpk_pkg::CMD_BYTE: begin
        if (neg || raw > 64'hff) verdict = tpk_pkg::ST_RANGE;
        else seq.push_back(raw[7:0]);
      end
      tpk_pkg::CMD_INT29, tpk_pkg::CMD_UINT29: begin
        if (cmd == tpk_pkg::CMD_INT29 ?
            (neg ? mag > 64'h1000_0000 : raw > 64'h0fff_ffff) :
            (neg || raw > 64'h1fff_ffff)) begin
          verdict = tpk_pkg::ST_RANGE;
        end else if (u <= 29'h7f) begin
          seq.push_back({1'b0, u[6:0]});
        end else if (u <= 29'h3fff) begin
          seq.push_back({1'b1, u[13:7]});
          seq.push_back({1'b0, u[6:0]});
        end else if (u <= 29'h1f_ffff) begin
          seq.push_back({1'b1, u[20:14]});
          seq.push_back({1'b1, u[13:7]});
          seq.push_back({1'b0, u[6:0]});
        end else begin
          // The fourth byte of the long form carries a full eight bits.
          seq.push_back({1'b1, u[28:22]});
          seq.push_back({1'b1, u[21:15]});
          seq.push_back({1'b1, u[14:8]});
          seq.push_back(u[7:0]);
        end
      end
      tpk_pkg::CMD_INT32, tpk_pkg::CMD_UINT32: begin
        if (cmd == tpk_pkg::CMD_INT32 ?
            (neg ? mag > 64'h8000_0000 : raw > 64'h7fff_ffff) :
            (neg || raw > 64'hffff_ffff)) begin
          verdict = tpk_pkg::ST_RANGE;
        end else begin
          for (int i = 3; i >= 0; i--) seq.push_back(raw[8*i +: 8]);
        end
      end
      tpk_pkg::CMD_DOUBLE: begin
        for (int i = 7; i >= 0; i--) seq.push_back(raw[8*i +: 8]);
      end
      default: verdict = tpk_pkg::ST_BADCMD;
    endcase
    if (verdict != tpk_pkg::ST_OK) begin
      owed.push_back(packed_byte_t'{data: 8'h00, fin: 1'b1, st: verdict});
      n_faults++;
    end else begin
      foreach (seq[k])
        owed.push_back(packed_byte_t'{data: seq[k], fin: (k == seq.size() - 1),
                                      st: tpk_pkg::ST_OK});
    end
  endfunction

  function void check_byte(logic [7:0] data, logic fin, logic [1:0] st);
    packed_byte_t want;
    if (owed.size() == 0) begin
      $error("unexpected result: out_byte 0x%02h, last %0b, status %0d", data, fin, st);
      n_errors++;
      return;
    end
    want = owed.pop_front();
    n_bytes++;
    if (data !== want.data) begin
      $error("out_byte: expected 0x%02h, got 0x%02h", want.data, data);
      n_errors++;
    end
    if (fin !== want.fin) begin
      $error("last: expected %0b, got %0b", want.fin, fin);
      n_errors++;
    end
    if (st !== want.st) begin
      $error("status: expected %0d, got %0d", want.st, st);
      n_errors++;
    end
  endfunction

endclass

module tb_typed_value_byte_packer_unit;
  import tpk_pkg::*;

  // The package names only the six valid commands; these are the two codes
  // that the block must reject.
  localparam logic [TPK_CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [TPK_CMD_W-1:0] CMD_RSVD7 = 3'd7;

  // Cycles with neither a request taken nor a byte shown before the run is
  // declared hung. The longest legal quiet stretch is a sender gap plus the
  // latency of the block, so this is ample.
  localparam int HANG_LIMIT = 400;

  // Cycles allowed after the last expected byte for any stray result.
  localparam int DRAIN_CYCLES = 16;

  localparam int RANDOM_REQUESTS = 134;

  // The last part of the run drives back-to-back requests with no idling.
  localparam int CALM_TAIL = 40;

  typedef struct packed {
    logic [TPK_CMD_W-1:0]   cmd;
    logic [TPK_VALUE_W-1:0] val;
  } request_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [TPK_CMD_W-1:0]          command = '0;
  logic signed [TPK_VALUE_W-1:0] value = '0;
  logic                          busy;
  logic                          strobe;
  logic [7:0]                    out_byte;
  logic                          last;
  logic [TPK_STATUS_W-1:0]       status;

  int                 quiet_cycles = 0;
  packed_byte_tracker expected_bytes;

  typed_value_byte_packer_unit dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .command  (command),
    .value    (value),
    .strobe   (strobe),
    .out_byte (out_byte),
    .last     (last),
    .status   (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Outputs are read at the rising edge, where they still hold the values of
  // the cycle that the edge ends, so each strobed byte is taken exactly once.
  always @(posedge clk) begin
    if (!rst && strobe) expected_bytes.check_byte(out_byte, last, status);
  end

  // Hang detection: any accepted request or shown byte counts as progress.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one request and holds it until the block takes it. A request is
  // taken at an edge where start was high and busy low during the cycle just
  // ended. Start is lowered only for a gap, so that a following request
  // keeps it high without a second assignment in the same step.
  task automatic send_request(input logic [TPK_CMD_W-1:0] cmd,
                              input logic [TPK_VALUE_W-1:0] val, input int gap);
    start   <= 1'b1;
    command <= cmd;
    value   <= val;
    do @(posedge clk); while (busy);
    expected_bytes.note_request(cmd, val);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    request_t                 plan[$];
    logic [TPK_CMD_W-1:0]     cmd;
    logic [TPK_VALUE_W-1:0]   r;
    logic [TPK_VALUE_W-1:0]   val;
    int unsigned              width;
    int                       gap;
    bit                       idle_mode;

    expected_bytes = new();

    // Directed requests: field extremes, every command, every boundary of
    // the variable-length form, each range limit on both sides, and both
    // reserved command codes.
    plan = '{
      '{CMD_BYTE,   64'd0},
      '{CMD_BYTE,   64'd255},
      '{CMD_BYTE,   64'd256},
      '{CMD_BYTE,   64'hffff_ffff_ffff_ffff},
      '{CMD_INT29,  64'd127},
      '{CMD_INT29,  64'd128},
      '{CMD_INT29,  64'h0000_0000_0000_3fff},
      '{CMD_INT29,  64'h0000_0000_001f_ffff},
      '{CMD_INT29,  64'h0000_0000_0fff_ffff},
      '{CMD_INT29,  64'hffff_ffff_f000_0000},
      '{CMD_INT29,  64'hffff_ffff_ffff_ffff},
      '{CMD_INT29,  64'h0000_0000_1000_0000},
      '{CMD_INT29,  64'hffff_ffff_efff_ffff},
      '{CMD_UINT29, 64'h0000_0000_1fff_ffff},
      '{CMD_UINT29, 64'h0000_0000_2000_0000},
      '{CMD_UINT29, 64'hffff_ffff_ffff_ffff},
      '{CMD_INT32,  64'h0000_0000_7fff_ffff},
      '{CMD_INT32,  64'hffff_ffff_8000_0000},
      '{CMD_INT32,  64'h0000_0000_8000_0000},
      '{CMD_INT32,  64'hffff_ffff_7fff_ffff},
      '{CMD_UINT32, 64'h0000_0000_ffff_ffff},
      '{CMD_UINT32, 64'h0000_0001_0000_0000},
      '{CMD_DOUBLE, 64'h8000_0000_0000_0000},
      '{CMD_DOUBLE, 64'h7fff_ffff_ffff_ffff},
      '{CMD_RSVD6,  64'h0000_0000_0000_0001},
      '{CMD_RSVD7,  64'hffff_ffff_ffff_ffff}
    };

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(1, 14)) : 0;
      send_request(plan[i].cmd, plan[i].val, gap);
    end

    // Random requests. Most carry an in-range value of a random bit length,
    // so that every size of the variable-length form keeps turning up; some
    // carry a value that is most likely out of range, a few a reserved code.
    // Idling comes in blocks of sixteen requests, either bursty or absent.
    idle_mode = 1'b0;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 16 == 0) idle_mode = 1'($urandom_range(0, 1));
      r = {$urandom, $urandom};
      cmd = ($urandom_range(0, 19) == 0) ? ($urandom_range(0, 1) ? CMD_RSVD6 : CMD_RSVD7)
                                         : TPK_CMD_W'($urandom_range(0, 5));
      if ($urandom_range(0, 9) == 0) begin
        val = $signed(r) >>> $urandom_range(0, 32);
      end else begin
        case (cmd)
          CMD_BYTE:   val = r >> 56;
          CMD_INT29:  begin width = $urandom_range(1, 29); val = $signed(r) >>> (64 - width); end
          CMD_UINT29: begin width = $urandom_range(1, 29); val = r >> (64 - width); end
          CMD_INT32:  begin width = $urandom_range(1, 32); val = $signed(r) >>> (64 - width); end
          CMD_UINT32: begin width = $urandom_range(1, 32); val = r >> (64 - width); end
          default:    val = r;
        endcase
      end
      gap = (i < RANDOM_REQUESTS - CALM_TAIL && idle_mode && $urandom_range(0, 2) != 0) ?
            int'($urandom_range(1, 14)) : 0;
      send_request(cmd, val, gap);
    end
    start <= 1'b0;

    // Let the queue drain; the hang counter bounds this wait.
    while (expected_bytes.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_bytes.owed.size() != 0) begin
      $error("%0d expected results never arrived", expected_bytes.owed.size());
      expected_bytes.n_errors++;
    end

    $display("Run covered %0d requests, %0d of them range faults or reserved codes, and %0d bytes.",
             expected_bytes.n_requests, expected_bytes.n_faults, expected_bytes.n_bytes);
    $display("Per command: byte %0d, int29 %0d, uint29 %0d, int32 %0d, uint32 %0d, double %0d.",
             expected_bytes.per_cmd[CMD_BYTE], expected_bytes.per_cmd[CMD_INT29],
             expected_bytes.per_cmd[CMD_UINT29], expected_bytes.per_cmd[CMD_INT32],
             expected_bytes.per_cmd[CMD_UINT32], expected_bytes.per_cmd[CMD_DOUBLE]);
    if (expected_bytes.n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
